FILE: rtl/dpbp_pkg.sv
// Package for the depth pixel back-projection block.
// Holds field widths, configuration register indexes and shared types.
// No dependencies.
package dpbp_pkg;

    // Width of the column and row counters
    localparam int COORD_BITS = 12;

    // Fixed field widths
    localparam int DEPTH_W  = 16;
    localparam int POS_W    = 32;
    localparam int COLOR_W  = 12;
    localparam int CENTER_W = 16;
    localparam int INV_W    = 32;
    localparam int STEP_W   = 8;
    localparam int SCALE_W  = 20;

    // Configuration port
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_SCALE_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_SCALE_Y = 3'd6;

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 2;

    // One kept pixel on its way to the back
    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [DEPTH_W-1:0]    depth;
    } dpbp_item_t;

    // Projection settings seen by the back
    typedef struct packed {
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [INV_W-1:0]    inv_focal_x;
        logic [INV_W-1:0]    inv_focal_y;
        logic [SCALE_W-1:0]  color_scale_x;
        logic [SCALE_W-1:0]  color_scale_y;
    } dpbp_proj_cfg_t;

endpackage

FILE: rtl/depth_pixel_back_projection.sv
// Top level of the depth pixel back-projection block: configuration registers,
// front, queue and back. Depends on dpbp_pkg, dpbp_front, dpbp_queue, dpbp_back.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  depth_mm, first_of_frame, last_of_row
//   out      output     out_valid/out_stall  x_pos, y_pos, z_mm, color_col, color_row
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// The front takes one pixel per cycle while the queue has room, kept or dropped.
// Each kept pixel passes through the back in four steps (load, depth multiply,
// focal multiply, saturate), and the back takes no new pixel until the last one
// has reached the output register. Reset clears counters, queue, back sequencer
// and output valid; configuration returns to its defaults. A stalled output holds
// the back, the queue then fills and raises in_stall.
module depth_pixel_back_projection (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dpbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dpbp_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [dpbp_pkg::DEPTH_W-1:0]     depth_mm,
    input  logic                             first_of_frame,
    input  logic                             last_of_row,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [dpbp_pkg::POS_W-1:0] x_pos,
    output logic signed [dpbp_pkg::POS_W-1:0] y_pos,
    output logic [dpbp_pkg::DEPTH_W-1:0]     z_mm,
    output logic [dpbp_pkg::COLOR_W-1:0]     color_col,
    output logic [dpbp_pkg::COLOR_W-1:0]     color_row
);
    import dpbp_pkg::*;

    dpbp_proj_cfg_t    proj_cfg_reg;
    logic [STEP_W-1:0] sample_step_reg;

    logic       push, pop, queue_full, queue_not_empty;
    dpbp_item_t push_item, pop_item;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proj_cfg_reg.center_x      <= '0;
            proj_cfg_reg.center_y      <= '0;
            proj_cfg_reg.inv_focal_x   <= '1;
            proj_cfg_reg.inv_focal_y   <= '1;
            proj_cfg_reg.color_scale_x <= SCALE_W'(20'h1_0000);
            proj_cfg_reg.color_scale_y <= SCALE_W'(20'h1_0000);
            sample_step_reg            <= STEP_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CENTER_X:      proj_cfg_reg.center_x      <= cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y:      proj_cfg_reg.center_y      <= cfg_data[CENTER_W-1:0];
                CFG_INV_FOCAL_X:   proj_cfg_reg.inv_focal_x   <= cfg_data[INV_W-1:0];
                CFG_INV_FOCAL_Y:   proj_cfg_reg.inv_focal_y   <= cfg_data[INV_W-1:0];
                CFG_SAMPLE_STEP:   sample_step_reg            <= cfg_data[STEP_W-1:0];
                CFG_COLOR_SCALE_X: proj_cfg_reg.color_scale_x <= cfg_data[SCALE_W-1:0];
                CFG_COLOR_SCALE_Y: proj_cfg_reg.color_scale_y <= cfg_data[SCALE_W-1:0];
                default:           ;
            endcase
        end
    end

    dpbp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .depth_mm       (depth_mm),
        .first_of_frame (first_of_frame),
        .last_of_row    (last_of_row),
        .sample_step    (sample_step_reg),
        .queue_full     (queue_full),
        .push           (push),
        .push_item      (push_item)
    );

    dpbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (queue_not_empty)
    );

    dpbp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (proj_cfg_reg),
        .item_ready (queue_not_empty),
        .item       (pop_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .x_pos      (x_pos),
        .y_pos      (y_pos),
        .z_mm       (z_mm),
        .color_col  (color_col),
        .color_row  (color_row)
    );

endmodule

FILE: rtl/dpbp_front.sv
// Front of the depth pixel back-projection block: raster counters and pixel selection.
// Depends on dpbp_pkg.
module dpbp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dpbp_pkg::DEPTH_W-1:0]  depth_mm,
    input  logic                          first_of_frame,
    input  logic                          last_of_row,
    input  logic [dpbp_pkg::STEP_W-1:0]   sample_step,
    input  logic                          queue_full,
    output logic                          push,
    output dpbp_pkg::dpbp_item_t          push_item
);
    import dpbp_pkg::*;

    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [STEP_W-1:0]     col_phase_reg, col_phase_next;
    logic [STEP_W-1:0]     row_phase_reg, row_phase_next;

    logic                  accept;
    logic                  keep;
    logic [COORD_BITS-1:0] cur_col, cur_row;
    logic [STEP_W-1:0]     cur_col_phase, cur_row_phase;

    // Advance a phase, wrapping at the sample step (zero step acts as one)
    function automatic logic [STEP_W-1:0] next_phase(
        input logic [STEP_W-1:0] phase,
        input logic [STEP_W-1:0] step
    );
        logic [STEP_W:0]   n;
        logic [STEP_W-1:0] step_eff;
        step_eff = (step == '0) ? STEP_W'(1) : step;
        n = {1'b0, phase} + (STEP_W+1)'(1);
        return (n >= {1'b0, step_eff}) ? '0 : n[STEP_W-1:0];
    endfunction

    assign in_stall = queue_full;
    assign accept   = in_valid & ~queue_full;

    // Frame start restarts the raster position for this pixel
    assign cur_col       = first_of_frame ? '0 : col_reg;
    assign cur_row       = first_of_frame ? '0 : row_reg;
    assign cur_col_phase = first_of_frame ? '0 : col_phase_reg;
    assign cur_row_phase = first_of_frame ? '0 : row_phase_reg;

    // Keep pixels on the sample grid that carry a measurement
    assign keep = (cur_col_phase == '0) && (cur_row_phase == '0) && (depth_mm != '0);
    assign push = accept & keep;

    assign push_item.col   = cur_col;
    assign push_item.row   = cur_row;
    assign push_item.depth = depth_mm;

    // Step to the next column, or to the next row at row end
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        if (accept)
        begin
            if (last_of_row)
            begin
                col_next       = '0;
                col_phase_next = '0;
                row_next       = cur_row + COORD_BITS'(1);
                row_phase_next = next_phase(cur_row_phase, sample_step);
            end
            else
            begin
                col_next       = cur_col + COORD_BITS'(1);
                col_phase_next = next_phase(cur_col_phase, sample_step);
                row_next       = cur_row;
                row_phase_next = cur_row_phase;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
        end
    end

endmodule

FILE: rtl/dpbp_queue.sv
// Short queue of kept pixels between the front and the back.
// Depends on dpbp_pkg.
module dpbp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dpbp_pkg::dpbp_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output dpbp_pkg::dpbp_item_t pop_item,
    output logic                 not_empty
);
    import dpbp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dpbp_item_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    // Move pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed pixel
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/dpbp_back.sv
// Back of the depth pixel back-projection block: pinhole projection, color
// coordinates and the output register. Depends on dpbp_pkg.
module dpbp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dpbp_pkg::dpbp_proj_cfg_t      cfg,
    input  logic                          item_ready,
    input  dpbp_pkg::dpbp_item_t          item,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [dpbp_pkg::POS_W-1:0]  x_pos,
    output logic signed [dpbp_pkg::POS_W-1:0]  y_pos,
    output logic [dpbp_pkg::DEPTH_W-1:0]  z_mm,
    output logic [dpbp_pkg::COLOR_W-1:0]  color_col,
    output logic [dpbp_pkg::COLOR_W-1:0]  color_row
);
    import dpbp_pkg::*;

    localparam int SHIFT_W = COORD_BITS + 4;
    localparam int DIFF_W  = ((SHIFT_W > CENTER_W) ? SHIFT_W : CENTER_W) + 1;
    localparam int MAG_W   = DIFF_W - 1;
    localparam int MAGP_W  = MAG_W + DEPTH_W + 1;
    localparam int HI_W    = MAGP_W - INV_W;
    localparam int HIP_W   = HI_W + INV_W;
    localparam int SUM_W   = HIP_W + 1;
    localparam int CPROD_W = COORD_BITS + SCALE_W;
    localparam int CSH_W   = CPROD_W - 16;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAG  = 2'd1;
    localparam logic [1:0] ST_INV  = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       load_out;

    logic [MAG_W:0]       abs_x, abs_y;
    logic                 neg_x_reg, neg_y_reg;
    logic [MAG_W-1:0]     mag_x_reg, mag_y_reg;
    logic [COORD_BITS-1:0] col_reg, row_reg;
    logic [DEPTH_W-1:0]   depth_reg;
    logic [MAGP_W-1:0]    magp_x_reg, magp_y_reg;
    logic [CPROD_W-1:0]   cprod_x_reg, cprod_y_reg;
    logic [INV_W-1:0]     lo_x_reg, lo_y_reg;
    logic [HIP_W-1:0]     hi_x_reg, hi_y_reg;
    logic [2*INV_W-1:0]   lo_prod_x, lo_prod_y;

    logic signed [POS_W-1:0] x_pos_reg, y_pos_reg;
    logic [DEPTH_W-1:0]      z_mm_reg;
    logic [COLOR_W-1:0]      color_col_reg, color_row_reg;

    // Sign and magnitude of 16*pos - center
    function automatic logic [MAG_W:0] abs_diff(
        input logic [COORD_BITS-1:0] pos,
        input logic [CENTER_W-1:0]   center
    );
        logic signed [DIFF_W-1:0] d;
        logic [DIFF_W-1:0]        m;
        d = $signed({{(DIFF_W-SHIFT_W){1'b0}}, pos, 4'b0000})
            - $signed({{(DIFF_W-CENTER_W){1'b0}}, center});
        m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        return {d[DIFF_W-1], m[MAG_W-1:0]};
    endfunction

    // Sum the partial products, saturate and apply the sign
    function automatic logic [POS_W-1:0] finish(
        input logic             neg,
        input logic [HIP_W-1:0] hi,
        input logic [INV_W-1:0] lo
    );
        logic [SUM_W-1:0] q;
        q = SUM_W'(hi) + SUM_W'(lo);
        if (!neg)
        begin
            return (q > SUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[POS_W-1:0];
        end
        return (q > SUM_W'(32'h8000_0000)) ? 32'h8000_0000 : (-q[POS_W-1:0]);
    endfunction

    // Drop the Q4.16 fraction and saturate to the color range
    function automatic logic [COLOR_W-1:0] color_sat(input logic [CPROD_W-1:0] p);
        logic [CSH_W-1:0] c;
        c = p[CPROD_W-1:16];
        return (c > CSH_W'({COLOR_W{1'b1}})) ? {COLOR_W{1'b1}} : c[COLOR_W-1:0];
    endfunction

    assign abs_x = abs_diff(item.col, cfg.center_x);
    assign abs_y = abs_diff(item.row, cfg.center_y);

    assign lo_prod_x = (2*INV_W)'(magp_x_reg[INV_W-1:0]) * (2*INV_W)'(cfg.inv_focal_x);
    assign lo_prod_y = (2*INV_W)'(magp_y_reg[INV_W-1:0]) * (2*INV_W)'(cfg.inv_focal_y);

    assign pop      = (state_reg == ST_IDLE) && item_ready;
    assign load_out = (state_reg == ST_SAT) && (!out_valid_reg || !out_stall);

    // Sequence one pixel through the arithmetic steps
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_ready)
                begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG:  state_next = ST_INV;
            ST_INV:  state_next = ST_SAT;
            ST_SAT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold a result until it is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Arithmetic datapath, one step per state
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            neg_x_reg <= abs_x[MAG_W];
            mag_x_reg <= abs_x[MAG_W-1:0];
            neg_y_reg <= abs_y[MAG_W];
            mag_y_reg <= abs_y[MAG_W-1:0];
            col_reg   <= item.col;
            row_reg   <= item.row;
            depth_reg <= item.depth;
        end
        if (state_reg == ST_MAG)
        begin
            magp_x_reg  <= MAGP_W'(mag_x_reg) * MAGP_W'(depth_reg);
            magp_y_reg  <= MAGP_W'(mag_y_reg) * MAGP_W'(depth_reg);
            cprod_x_reg <= CPROD_W'(col_reg) * CPROD_W'(cfg.color_scale_x);
            cprod_y_reg <= CPROD_W'(row_reg) * CPROD_W'(cfg.color_scale_y);
        end
        if (state_reg == ST_INV)
        begin
            lo_x_reg <= lo_prod_x[2*INV_W-1:INV_W];
            lo_y_reg <= lo_prod_y[2*INV_W-1:INV_W];
            hi_x_reg <= HIP_W'(magp_x_reg[MAGP_W-1:INV_W]) * HIP_W'(cfg.inv_focal_x);
            hi_y_reg <= HIP_W'(magp_y_reg[MAGP_W-1:INV_W]) * HIP_W'(cfg.inv_focal_y);
        end
        if (load_out)
        begin
            x_pos_reg     <= $signed(finish(neg_x_reg, hi_x_reg, lo_x_reg));
            y_pos_reg     <= $signed(finish(neg_y_reg, hi_y_reg, lo_y_reg));
            z_mm_reg      <= depth_reg;
            color_col_reg <= color_sat(cprod_x_reg);
            color_row_reg <= color_sat(cprod_y_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign x_pos     = x_pos_reg;
    assign y_pos     = y_pos_reg;
    assign z_mm      = z_mm_reg;
    assign color_col = color_col_reg;
    assign color_row = color_row_reg;

endmodule

FILE: sim/tb.sv
// Testbench for depth_pixel_back_projection: random and directed depth pixels
// against an in-bench model of the pinhole back-projection, checked point by point.
// Depends on rtl/dpbp_pkg.sv and the block's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dpbp_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 10;
    localparam int MAX_GAP        = 11;
    localparam int DRAIN_CYCLES   = 16;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 8;
    localparam int RANDOM_ITEMS   = 215;
    localparam int HOLD_AT        = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [DEPTH_W-1:0] depth;
        logic               first;
        logic               last;
    } pixel_t;

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [DEPTH_W-1:0]      z;
        logic [COLOR_W-1:0]      col;
        logic [COLOR_W-1:0]      row;
    } point_t;

    // Clock, reset and block ports
    logic                     clk            = 1'b0;
    logic                     rst_n          = 1'b0;
    logic                     cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index      = '0;
    logic [CFG_W-1:0]         cfg_data       = '0;
    logic                     in_valid       = 1'b0;
    logic                     in_stall;
    logic [DEPTH_W-1:0]       depth_mm       = '0;
    logic                     first_of_frame = 1'b0;
    logic                     last_of_row    = 1'b0;
    logic                     out_valid;
    logic                     out_stall      = 1'b0;
    logic signed [POS_W-1:0]  x_pos;
    logic signed [POS_W-1:0]  y_pos;
    logic [DEPTH_W-1:0]       z_mm;
    logic [COLOR_W-1:0]       color_col;
    logic [COLOR_W-1:0]       color_row;

    // Settings as the block should hold them
    logic [CENTER_W-1:0]      cur_center_x    = '0;
    logic [CENTER_W-1:0]      cur_center_y    = '0;
    logic [INV_W-1:0]         cur_inv_focal_x = '1;
    logic [INV_W-1:0]         cur_inv_focal_y = '1;
    logic [STEP_W-1:0]        cur_step        = 8'd1;
    logic [SCALE_W-1:0]       cur_scale_x     = 20'h10000;
    logic [SCALE_W-1:0]       cur_scale_y     = 20'h10000;

    // Raster position as the block should track it
    logic [COORD_BITS-1:0]    col_cnt = '0;
    logic [COORD_BITS-1:0]    row_cnt = '0;
    logic [STEP_W-1:0]        col_ph  = '0;
    logic [STEP_W-1:0]        row_ph  = '0;

    pixel_t                   pixel_q[$];
    point_t                   expected_points[$];
    point_t                   want_pt;
    pixel_t                   next_px;

    int                       pixels_taken    = 0;
    int                       points_seen     = 0;
    int                       error_count     = 0;
    int                       settings_loaded = 0;
    int                       idle_cycles     = 0;
    int                       hold_left       = 0;
    bit                       hold_done       = 1'b0;
    int                       tx_gap          = 0;
    int                       rx_gap          = 0;
    bit                       tx_offer        = 1'b0;
    bit                       tx_steady       = 1'b0;
    bit                       rx_steady       = 1'b0;

    depth_pixel_back_projection u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .depth_mm       (depth_mm),
        .first_of_frame (first_of_frame),
        .last_of_row    (last_of_row),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .x_pos          (x_pos),
        .y_pos          (y_pos),
        .z_mm           (z_mm),
        .color_col      (color_col),
        .color_row      (color_row)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // (16*pos - center) * depth * inv / 2^32, truncated toward zero, saturated
    function automatic logic [POS_W-1:0] back_project(input logic [COORD_BITS-1:0] pos,
                                                      input logic [CENTER_W-1:0] center,
                                                      input logic [DEPTH_W-1:0] depth,
                                                      input logic [INV_W-1:0] inv);
        longint     offset;
        bit         neg;
        logic [63:0] scaled;
        logic [95:0] product;
        logic [63:0] quotient;
        offset   = longint'(pos) * 16 - longint'(center);
        neg      = offset < 0;
        scaled   = 64'(neg ? -offset : offset) * 64'(depth);
        product  = 96'(scaled) * 96'(inv);
        quotient = product[95:32];
        if (!neg)
            return (quotient > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quotient[31:0];
        if (quotient > 64'h8000_0000)
            quotient = 64'h8000_0000;
        return 32'd0 - quotient[31:0];
    endfunction

    // Scale a depth coordinate into the color image, clip to the 12-bit range
    function automatic logic [COLOR_W-1:0] color_coord(input logic [COORD_BITS-1:0] pos,
                                                       input logic [SCALE_W-1:0] scale);
        logic [47:0] product;
        product = 48'(pos) * 48'(scale);
        product = product >> 16;
        return (product > 48'd4095) ? 12'd4095 : product[COLOR_W-1:0];
    endfunction

    // Advance a sampling phase; a zero step acts as one
    function automatic logic [STEP_W-1:0] advance_phase(input logic [STEP_W-1:0] phase);
        logic [STEP_W:0]   n;
        logic [STEP_W-1:0] step;
        step = (cur_step == '0) ? 8'd1 : cur_step;
        n    = {1'b0, phase} + 9'd1;
        return (n >= {1'b0, step}) ? '0 : n[STEP_W-1:0];
    endfunction

    // Track raster position for one taken pixel and queue its point if kept
    function automatic void project_pixel(input logic [DEPTH_W-1:0] depth,
                                          input logic first, input logic last);
        point_t pt;
        if (first)
        begin
            col_cnt = '0;
            row_cnt = '0;
            col_ph  = '0;
            row_ph  = '0;
        end
        if (col_ph == '0 && row_ph == '0 && depth != '0)
        begin
            pt.x   = back_project(col_cnt, cur_center_x, depth, cur_inv_focal_x);
            pt.y   = back_project(row_cnt, cur_center_y, depth, cur_inv_focal_y);
            pt.z   = depth;
            pt.col = color_coord(col_cnt, cur_scale_x);
            pt.row = color_coord(row_cnt, cur_scale_y);
            expected_points.push_back(pt);
        end
        if (last)
        begin
            col_cnt = '0;
            col_ph  = '0;
            row_cnt = row_cnt + COORD_BITS'(1);
            row_ph  = advance_phase(row_ph);
        end
        else
        begin
            col_cnt = col_cnt + COORD_BITS'(1);
            col_ph  = advance_phase(col_ph);
        end
    endfunction

    function automatic logic [DEPTH_W-1:0] rand_depth();
        case ($urandom_range(0, 15))
            0, 1:    return '0;
            2:       return 16'hFFFF;
            3:       return 16'd1;
            4:       return 16'($urandom_range(1, 255));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void push_pixel(input logic [DEPTH_W-1:0] depth,
                                       input logic first, input logic last);
        pixel_t px;
        px.depth = depth;
        px.first = first;
        px.last  = last;
        pixel_q.push_back(px);
    endfunction

    // Queue a raster frame, optionally without its start flag, stopping after cut pixels
    function automatic int add_frame(input int width, input int height,
                                     input bit with_start, input int cut);
        int n;
        n = 0;
        for (int r = 0; r < height; r++)
            for (int c = 0; c < width; c++)
                if (n < cut)
                begin
                    push_pixel(rand_depth(), with_start && r == 0 && c == 0, c == width - 1);
                    n++;
                end
        return n;
    endfunction

    function automatic logic [CENTER_W-1:0] pick_center();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(2000, 12000));
        endcase
    endfunction

    function automatic logic [INV_W-1:0] pick_inv();
        case ($urandom_range(0, 3))
            0:       return 32'd1;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom();
            default: return $urandom_range(2000000, 20000000);
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 3))
            0:       return 20'h10000;
            1:       return 20'hFFFFF;
            2:       return 20'($urandom_range(0, 20'hFFFFF));
            default: return 20'($urandom_range(20'h10000, 20'h30000));
        endcase
    endfunction

    // Drive one register write; the mirror follows at once since the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_CENTER_X:      cur_center_x    = value[CENTER_W-1:0];
            CFG_CENTER_Y:      cur_center_y    = value[CENTER_W-1:0];
            CFG_INV_FOCAL_X:   cur_inv_focal_x = value[INV_W-1:0];
            CFG_INV_FOCAL_Y:   cur_inv_focal_y = value[INV_W-1:0];
            CFG_SAMPLE_STEP:   cur_step        = value[STEP_W-1:0];
            CFG_COLOR_SCALE_X: cur_scale_x     = value[SCALE_W-1:0];
            CFG_COLOR_SCALE_Y: cur_scale_y     = value[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_settings(input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy,
                                 input logic [INV_W-1:0] fx, input logic [INV_W-1:0] fy,
                                 input logic [STEP_W-1:0] step,
                                 input logic [SCALE_W-1:0] sx, input logic [SCALE_W-1:0] sy);
        write_reg(CFG_CENTER_X, 32'(cx));
        write_reg(CFG_CENTER_Y, 32'(cy));
        write_reg(CFG_INV_FOCAL_X, fx);
        write_reg(CFG_INV_FOCAL_Y, fy);
        write_reg(CFG_SAMPLE_STEP, 32'(step));
        write_reg(CFG_COLOR_SCALE_X, 32'(sx));
        write_reg(CFG_COLOR_SCALE_Y, 32'(sy));
        end_writes();
        settings_loaded++;
    endtask

    task automatic random_settings();
        logic [STEP_W-1:0] step;
        case ($urandom_range(0, 7))
            0, 1:    step = 8'd1;
            2:       step = 8'd2;
            3:       step = 8'd3;
            4:       step = 8'd4;
            5:       step = 8'($urandom_range(5, 9));
            6:       step = 8'($urandom_range(10, 255));
            default: step = 8'd255;
        endcase
        load_settings(pick_center(), pick_center(), pick_inv(), pick_inv(), step,
                      pick_scale(), pick_scale());
    endtask

    // Wait until every pixel is taken and every point has left, then let the pipe settle
    task automatic drain();
        do
            @(negedge clk);
        while (pixel_q.size() != 0 || in_valid || expected_points.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Pixel driver: retire taken pixels into the model, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            depth_mm       <= '0;
            first_of_frame <= 1'b0;
            last_of_row    <= 1'b0;
            pixels_taken   <= 0;
            tx_gap = 0;
        end
        else
        begin
            tx_offer = in_valid;
            if (in_valid && !in_stall)
            begin
                project_pixel(depth_mm, first_of_frame, last_of_row);
                pixels_taken <= pixels_taken + 1;
                tx_gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 39) == 0)
                    tx_steady = !tx_steady;
                tx_offer = 1'b0;
            end
            if (!tx_offer)
            begin
                if (tx_gap != 0)
                    tx_gap = tx_gap - 1;
                else if (pixel_q.size() != 0)
                begin
                    next_px = pixel_q.pop_front();
                    depth_mm       <= next_px.depth;
                    first_of_frame <= next_px.first;
                    last_of_row    <= next_px.last;
                    tx_offer = 1'b1;
                end
            end
            in_valid <= tx_offer;
        end
    end

    // Long output hold once, so the queue fills and the input stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && pixels_taken >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Point monitor: compare each transaction with the oldest expected point
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("point %0d unexpected: x=%0d y=%0d z=%0d col=%0d row=%0d",
                                 points_seen, x_pos, y_pos, z_mm, color_col, color_row);
                end
                else
                begin
                    want_pt = expected_points.pop_front();
                    if (x_pos !== want_pt.x || y_pos !== want_pt.y || z_mm !== want_pt.z ||
                        color_col !== want_pt.col || color_row !== want_pt.row)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                        begin
                            $display("point %0d expected x=%0d y=%0d z=%0d col=%0d row=%0d",
                                     points_seen, want_pt.x, want_pt.y, want_pt.z,
                                     want_pt.col, want_pt.row);
                            $display("point %0d actual   x=%0d y=%0d z=%0d col=%0d row=%0d",
                                     points_seen, x_pos, y_pos, z_mm, color_col, color_row);
                        end
                    end
                end
                points_seen++;
                rx_gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 39) == 0)
                    rx_steady = !rx_steady;
            end
            else if (rx_gap != 0)
                rx_gap = rx_gap - 1;
            out_stall <= (rx_gap != 0) || (hold_left != 0);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: %0d cycles without a transaction", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int added;
        int width;
        int height;
        int n;
        int left;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: zero center, full inverse focal, step one, unit scale
        push_pixel(16'd1, 1'b1, 1'b0);
        push_pixel(16'hFFFF, 1'b0, 1'b0);
        push_pixel(16'd0, 1'b0, 1'b0);
        push_pixel(16'h5555, 1'b0, 1'b0);
        push_pixel(16'hAAAA, 1'b0, 1'b1);
        push_pixel(16'h8000, 1'b1, 1'b1);
        push_pixel(16'h7FFF, 1'b0, 1'b0);
        push_pixel(16'd1234, 1'b0, 1'b1);

        // Far center and full scales: negative saturation, color range edge
        drain();
        load_settings(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1,
                      20'hFFFFF, 20'hFFFFF);
        push_pixel(16'hFFFF, 1'b1, 1'b0);
        push_pixel(16'hFFFF, 1'b0, 1'b1);
        push_pixel(16'd300, 1'b0, 1'b0);
        push_pixel(16'd1, 1'b0, 1'b1);

        // Zero step keeps every pixel; zero inverse focal gives zero X and Y
        drain();
        load_settings(16'd5120, 16'd3840, 32'd0, 32'd0, 8'd0, 20'd0, 20'h10000);
        push_pixel(16'd500, 1'b1, 1'b0);
        push_pixel(16'd501, 1'b0, 1'b1);
        push_pixel(16'd502, 1'b0, 1'b0);

        // Step cut mid-frame: phases left beyond the new step fall back to zero
        drain();
        load_settings(16'd5000, 16'd3700, 32'd7158278, 32'd7158278, 8'd5,
                      20'h18000, 20'h18000);
        push_pixel(16'd900, 1'b1, 1'b1);
        push_pixel(16'd901, 1'b0, 1'b1);
        push_pixel(16'd902, 1'b0, 1'b1);
        for (int c = 0; c < 4; c++)
            push_pixel(16'(1000 + c), 1'b0, 1'b0);
        drain();
        write_reg(CFG_SAMPLE_STEP, 32'd2);
        end_writes();
        for (int c = 0; c < 4; c++)
            push_pixel(16'(1100 + c), 1'b0, c == 3);
        push_pixel(16'd1200, 1'b0, 1'b0);
        push_pixel(16'd1201, 1'b0, 1'b1);

        // Random settings; mostly whole frames, some without start, cut short or noise
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            random_settings();
            added = 0;
            while (added < RANDOM_ITEMS)
            begin
                width  = $urandom_range(1, 40);
                height = $urandom_range(1, 10);
                left   = RANDOM_ITEMS - added;
                case ($urandom_range(0, 9))
                    7: added += add_frame(width, height, 1'b0, left);
                    8:
                    begin
                        n = $urandom_range(1, 16);
                        if (n > left)
                            n = left;
                        for (int i = 0; i < n; i++)
                            push_pixel(rand_depth(), $urandom_range(0, 15) == 0,
                                       $urandom_range(0, 3) == 0);
                        added += n;
                    end
                    9:
                    begin
                        n = $urandom_range(1, width * height);
                        if (n > left)
                            n = left;
                        added += add_frame(width, height, 1'b1, n);
                    end
                    default: added += add_frame(width, height, 1'b1, left);
                endcase
            end
        end

        drain();
        $display("Run: %0d depth pixels in, %0d points checked, %0d settings loaded, %0d bad",
                 pixels_taken, points_seen, settings_loaded, error_count);
        $display("Covered: field extremes, zero step and focal, step cut mid-frame, %s",
                 "saturation and a long output hold");
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
